// ----- rtl/p2ba_pkg.sv -----
// Shared types, codes and helpers for the power-of-two block allocator.
// No dependencies; imported by pow2_block_allocator_unit.
package p2ba_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int POS_W      = 16;
    localparam int EXP_W      = 4;
    localparam int CFG_W      = 11;

    localparam logic       OP_ALLOC    = 1'b0;
    localparam logic       OP_FREE     = 1'b1;

    localparam logic [1:0] STAT_ALLOC  = 2'd0;
    localparam logic [1:0] STAT_OOM    = 2'd1;
    localparam logic [1:0] STAT_FREED  = 2'd2;
    localparam logic [1:0] STAT_NULL   = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [9:0]  request_size;
        logic [9:0]  free_offset;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  result_offset;
        logic [3:0]  block_exponent;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_CHECK,
        ST_A_SCAN,
        ST_F_READ,
        ST_F_MARK,
        ST_F_CLEAR,
        ST_DONE
    } state_t;

    // Smallest e >= 1 with 2^e >= req + 1, i.e. the bit length of req.
    function automatic logic [EXP_W-1:0] exp_for(input logic [9:0] req);
        logic [EXP_W-1:0] e;
        e = EXP_W'(1);
        for (int b = 1; b < 10; b++)
        begin
            if (req[b])
            begin
                e = EXP_W'(b + 1);
            end
        end
        return e;
    endfunction

endpackage

// ----- rtl/pow2_block_allocator_unit.sv -----
// First-fit power-of-two block allocator over a per-byte marker store.
// Depends on p2ba_pkg for payload types, state codes and the exponent helper.
//
//   channel   signals                                  direction
//   in        in_valid, in_stall, in_data (in_item_t)  operation request
//   out       out_valid, out_stall, out_data           one result per request
//   cfg       cfg_write, cfg_data                      pool_bytes register
//
// One transaction at a time; in_stall is low only in the idle state.
// Allocate: accept, first fit check, done, plus a scan step per marker read by
// the single store read port and a fresh fit check per hop; free: accept, read,
// mark, done, plus a clear step per cleared marker (2^exponent, cut at the store end).
// After reset a clearing pass zeroes the store, with in_stall high.
// A finished result waits in the output register; a new request is accepted
// meanwhile, and the next result waits in the done state while out_stall holds.
module pow2_block_allocator_unit
    import p2ba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_write,
    input  logic [CFG_W-1:0] cfg_data
);

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     pool_bytes_reg;
    logic [ADDR_W-1:0]    cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic [EXP_W-1:0]     exp_reg, exp_next;
    logic [ADDR_W-1:0]    hdr_reg, hdr_next;
    logic [EXP_W-1:0]     mark_reg, mark_next;
    logic [ADDR_W:0]      end_reg, end_next;
    out_item_t            res_reg, res_next;

    logic [EXP_W-1:0]     mem [POOL_DEPTH];
    logic [EXP_W-1:0]     rd_data_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [EXP_W-1:0]     wr_data;

    logic                 accept;
    logic                 out_free;
    logic [CFG_W-1:0]     pool_eff;
    logic [ADDR_W:0]      size_w;
    logic                 fit;
    logic [POS_W-1:0]     skip_pos;
    logic                 idx_last;
    logic [POS_W-1:0]     end_sum;
    logic [ADDR_W:0]      end_clamp;
    logic [ADDR_W:0]      cnt_inc;
    logic                 clear_last;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign pool_eff = (pool_bytes_reg > CFG_W'(POOL_DEPTH)) ? CFG_W'(POOL_DEPTH)
                                                            : pool_bytes_reg;
    assign size_w   = {{ADDR_W{1'b0}}, 1'b1} << exp_reg;
    assign fit      = (pos_reg + POS_W'(size_w)) <= POS_W'(pool_eff);
    // Hop past the marker just read, counted from where it was found.
    assign skip_pos = pos_reg + POS_W'(idx_reg) + (POS_W'(1) << rd_data_reg);
    assign idx_last = ({1'b0, idx_reg} + {{ADDR_W{1'b0}}, 1'b1}) == size_w;
    assign end_sum  = POS_W'(hdr_reg) + (POS_W'(1) << rd_data_reg);
    assign end_clamp = (end_sum > POS_W'(POOL_DEPTH)) ? (ADDR_W + 1)'(POOL_DEPTH)
                                                      : end_sum[ADDR_W:0];
    assign cnt_inc    = {1'b0, cnt_reg} + {{ADDR_W{1'b0}}, 1'b1};
    assign clear_last = (cnt_reg == {ADDR_W{1'b1}});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.operation == OP_ALLOC)
                    begin
                        state_next = ST_A_CHECK;
                    end
                    else if (in_data.free_offset == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_F_READ;
                    end
                end
            end
            ST_A_CHECK:
            begin
                state_next = fit ? ST_A_SCAN : ST_DONE;
            end
            ST_A_SCAN:
            begin
                if (rd_data_reg != '0)
                begin
                    state_next = ST_A_CHECK;
                end
                else if (idx_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_F_READ:
            begin
                state_next = ST_F_MARK;
            end
            ST_F_MARK:
            begin
                state_next = ST_F_CLEAR;
            end
            ST_F_CLEAR:
            begin
                if (cnt_inc == end_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Datapath and store control
    always_comb
    begin
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        exp_next       = exp_reg;
        hdr_next       = hdr_reg;
        mark_next      = mark_reg;
        end_next       = end_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        rd_addr        = pos_reg[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_inc[ADDR_W-1:0];
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    exp_next = exp_for(in_data.request_size);
                    hdr_next = in_data.free_offset - {{(ADDR_W - 1){1'b0}}, 1'b1};
                    pos_next = '0;
                    idx_next = '0;
                    res_next = '{status: STAT_NULL, result_offset: '0,
                                 block_exponent: '0};
                end
            end
            ST_A_CHECK:
            begin
                idx_next = '0;
                if (!fit)
                begin
                    res_next = '{status: STAT_OOM, result_offset: '0,
                                 block_exponent: '0};
                end
            end
            ST_A_SCAN:
            begin
                // Prefetch the following position of the candidate block.
                rd_addr = pos_reg[ADDR_W-1:0] + idx_reg + {{(ADDR_W - 1){1'b0}}, 1'b1};
                if (rd_data_reg != '0)
                begin
                    pos_next = skip_pos;
                end
                else if (idx_last)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg[ADDR_W-1:0];
                    wr_data  = exp_reg;
                    res_next = '{status: STAT_ALLOC,
                                 result_offset: pos_reg[ADDR_W-1:0]
                                                + {{(ADDR_W - 1){1'b0}}, 1'b1},
                                 block_exponent: exp_reg};
                end
                else
                begin
                    idx_next = idx_reg + {{(ADDR_W - 1){1'b0}}, 1'b1};
                end
            end
            ST_F_READ:
            begin
                rd_addr = hdr_reg;
            end
            ST_F_MARK:
            begin
                mark_next = rd_data_reg;
                end_next  = end_clamp;
                cnt_next  = hdr_reg;
            end
            ST_F_CLEAR:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_inc[ADDR_W-1:0];
                res_next = '{status: STAT_FREED, result_offset: '0,
                             block_exponent: mark_reg};
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pool_bytes_reg <= CFG_W'(1024);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                pool_bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        exp_reg      <= exp_next;
        hdr_reg      <= hdr_next;
        mark_reg     <= mark_next;
        end_reg      <= end_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // Marker store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef ASSERT_OFF
    a_scan_inside_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_SCAN) |-> ({1'b0, idx_reg} < size_w))
        else $error("scan index ran past the candidate block");

    a_free_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_F_CLEAR) |-> ({1'b0, cnt_reg} < end_reg))
        else $error("free walk ran past its end");

    a_alloc_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == STAT_ALLOC)
            |-> (out_data_reg.result_offset != '0 && out_data_reg.block_exponent != '0))
        else $error("allocation result without offset or exponent");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result issued outside the done state");
`endif

endmodule
